@@ design/sha1h_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1h_pkg
// Shared types and constants for the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sha1h_pkg;

    localparam int WORD_IDX_W = 4;
    localparam int ROUNDS     = 80;
    localparam int ROUND_W    = 7;

    typedef logic [4:0][31:0] digest_t;

    typedef struct packed {
        logic                  load_en;
        logic [WORD_IDX_W-1:0] load_idx;
        logic [7:0]            load_byte;
        logic                  shift;
    } sched_ctl_t;

    typedef struct packed {
        logic               start;
        logic               step;
        logic               add;
        logic               init;
        logic [ROUND_W-1:0] rnd;
    } core_ctl_t;

endpackage

@@ design/sha1h_in_if.sv @@
// ----------------------------------------------------------------------------
// sha1h_in_if
// Input channel: one message byte word with its has_byte and last flags.
// ----------------------------------------------------------------------------
interface sha1h_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, data_byte, has_byte, last, input ready);
    modport sink   (input valid, data_byte, has_byte, last, output ready);
endinterface

@@ design/sha1h_out_if.sv @@
// ----------------------------------------------------------------------------
// sha1h_out_if
// Output channel: one 160-bit digest word split into five 32-bit fields.
// ----------------------------------------------------------------------------
interface sha1h_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_h0;
    logic [31:0] digest_h1;
    logic [31:0] digest_h2;
    logic [31:0] digest_h3;
    logic [31:0] digest_h4;

    modport source (output valid, digest_h0, digest_h1, digest_h2, digest_h3, digest_h4,
                    input ready);
    modport sink   (input valid, digest_h0, digest_h1, digest_h2, digest_h3, digest_h4,
                    output ready);
endinterface

@@ design/sha1_byte_stream_hasher_top.sv @@
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_top
// SHA-1 over a byte stream: packing, padding, 80-round compression, digest.
// ----------------------------------------------------------------------------
// Flow: a byte that does not complete a block leaves the input ready; a byte
//   that completes a block starts a compression (80 rounds on the shared round
//   unit, then one chaining add), ready held low meanwhile.
// A last word is followed by one load per padding and length byte, one or two
//   compressions, then a load of the digest register.
// Bytes are not taken while a block is being compressed.
// Reset: rst_n clears control state and restores the SHA-1 initial chain.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_top
    import sha1h_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    sha1h_in_if.sink     in_ch,
    sha1h_out_if.source  out_ch
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ROUND = 3'd1;
    localparam logic [2:0] ST_ADD   = 3'd2;
    localparam logic [2:0] ST_MARK  = 3'd3;
    localparam logic [2:0] ST_ZERO  = 3'd4;
    localparam logic [2:0] ST_LEN   = 3'd5;
    localparam logic [2:0] ST_EMIT  = 3'd6;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [5:0] LEN_START = 6'd56;

    logic [2:0]         state_reg, state_next;
    logic [2:0]         ret_reg, ret_next;        // where to go after the chaining add
    logic [5:0]         idx_reg, idx_next;        // bytes held in the current block
    logic [5:0]         idx_inc;
    logic [54:0]        cnt_reg, cnt_next;        // full blocks so far
    logic [63:0]        len_reg, len_next;        // bit length, shifted out MSB first
    logic [ROUND_W-1:0] rnd_reg, rnd_next;
    logic               out_valid_reg, out_valid_next;
    digest_t            digest_reg;
    logic               out_load;

    sched_ctl_t         sctl;
    core_ctl_t          cctl;
    logic [31:0]        w_cur;
    digest_t            chain;

    assign idx_inc     = idx_reg + 6'd1;
    assign in_ch.ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        rnd_next       = rnd_reg;
        out_load       = 1'b0;
        sctl.load_en   = 1'b0;
        sctl.load_idx  = idx_reg[5:2];
        sctl.load_byte = in_ch.data_byte;
        sctl.shift     = 1'b0;
        cctl.start     = 1'b0;
        cctl.step      = 1'b0;
        cctl.add       = 1'b0;
        cctl.init      = 1'b0;
        cctl.rnd       = rnd_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    if (in_ch.has_byte)
                    begin
                        sctl.load_en = 1'b1;
                        idx_next     = idx_inc;
                        if (idx_inc == 6'd0)
                        begin
                            cnt_next = cnt_reg + 55'd1;
                        end
                    end
                    // Capture the message bit length in case this word ends it.
                    len_next = {cnt_next, idx_next, 3'b000};
                    if (in_ch.has_byte && idx_inc == 6'd0)
                    begin
                        state_next = ST_ROUND;
                        rnd_next   = '0;
                        cctl.start = 1'b1;
                        ret_next   = in_ch.last ? ST_MARK : ST_IDLE;
                    end
                    else if (in_ch.last)
                    begin
                        state_next = ST_MARK;
                    end
                end
            end

            ST_ROUND:
            begin
                cctl.step  = 1'b1;
                sctl.shift = 1'b1;
                rnd_next   = rnd_reg + ROUND_W'(1);
                if (rnd_reg == ROUND_W'(ROUNDS - 1))
                begin
                    state_next = ST_ADD;
                end
            end

            ST_ADD:
            begin
                cctl.add   = 1'b1;
                state_next = ret_reg;
            end

            ST_MARK, ST_ZERO, ST_LEN:
            begin
                sctl.load_en = 1'b1;
                idx_next     = idx_inc;
                case (state_reg)
                    ST_MARK: sctl.load_byte = PAD_BYTE;
                    ST_LEN:  sctl.load_byte = len_reg[63:56];
                    default: sctl.load_byte = 8'h00;
                endcase
                if (state_reg == ST_LEN)
                begin
                    len_next = {len_reg[55:0], 8'h00};
                end
                if (idx_inc == 6'd0)
                begin
                    state_next = ST_ROUND;
                    rnd_next   = '0;
                    cctl.start = 1'b1;
                    ret_next   = (state_reg == ST_LEN) ? ST_EMIT : ST_ZERO;
                end
                else if (idx_inc == LEN_START && state_reg != ST_LEN)
                begin
                    state_next = ST_LEN;
                end
                else if (state_reg == ST_MARK)
                begin
                    state_next = ST_ZERO;
                end
            end

            ST_EMIT:
            begin
                // Hold until the digest register is free, then restart the chain.
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_load   = 1'b1;
                    cctl.init  = 1'b1;
                    idx_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: bit length and the held digest word.
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        if (out_load)
        begin
            digest_reg <= chain;
        end
    end

    sha1h_sched u_sched
    (
        .clk   (clk),
        .ctl   (sctl),
        .w_cur (w_cur)
    );

    sha1h_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cctl),
        .w_cur (w_cur),
        .chain (chain)
    );

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.digest_h0 = digest_reg[0];
    assign out_ch.digest_h1 = digest_reg[1];
    assign out_ch.digest_h2 = digest_reg[2];
    assign out_ch.digest_h3 = digest_reg[3];
    assign out_ch.digest_h4 = digest_reg[4];

endmodule

@@ design/sha1h_sched.sv @@
// ----------------------------------------------------------------------------
// sha1h_sched
// Block buffer and message schedule: 16-word window, byte loading, expansion.
// ----------------------------------------------------------------------------
module sha1h_sched
    import sha1h_pkg::*;
(
    input  logic        clk,
    input  sched_ctl_t  ctl,
    output logic [31:0] w_cur
);

    logic [31:0] w_reg [16];
    logic [31:0] mix;
    logic [31:0] w_new;

    assign mix   = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
    assign w_new = {mix[30:0], mix[31]};
    assign w_cur = w_reg[0];

    // Shift the window once per round; pack bytes big-endian otherwise.
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
        end
        else if (ctl.load_en)
        begin
            w_reg[ctl.load_idx] <= {w_reg[ctl.load_idx][23:0], ctl.load_byte};
        end
    end

endmodule

@@ design/sha1h_core.sv @@
// ----------------------------------------------------------------------------
// sha1h_core
// Shared SHA-1 round unit with working registers and chaining words.
// ----------------------------------------------------------------------------
module sha1h_core
    import sha1h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  core_ctl_t   ctl,
    input  logic [31:0] w_cur,
    output digest_t     chain
);

    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;
    localparam digest_t     IV = {32'hc3d2e1f0, 32'h10325476, 32'h98badcfe,
                                  32'hefcdab89, 32'h67452301};

    digest_t     chain_reg;
    digest_t     chain_next;
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] t_val;

    always_comb
    begin
        if (ctl.rnd < ROUND_W'(20))
        begin
            f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            k_val = K0;
        end
        else if (ctl.rnd < ROUND_W'(40))
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K1;
        end
        else if (ctl.rnd < ROUND_W'(60))
        begin
            f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
            k_val = K2;
        end
        else
        begin
            f_val = b_reg ^ c_reg ^ d_reg;
            k_val = K3;
        end
    end

    assign t_val = {a_reg[26:0], a_reg[31:27]} + f_val + e_reg + k_val + w_cur;

    always_comb
    begin
        chain_next = chain_reg;
        if (ctl.init)
        begin
            chain_next = IV;
        end
        else if (ctl.add)
        begin
            chain_next[0] = chain_reg[0] + a_reg;
            chain_next[1] = chain_reg[1] + b_reg;
            chain_next[2] = chain_reg[2] + c_reg;
            chain_next[3] = chain_reg[3] + d_reg;
            chain_next[4] = chain_reg[4] + e_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= IV;
        end
        else
        begin
            chain_reg <= chain_next;
        end
    end

    // Load working words at block start, advance one round per step.
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
            e_reg <= chain_reg[4];
        end
        else if (ctl.step)
        begin
            e_reg <= d_reg;
            d_reg <= c_reg;
            c_reg <= {b_reg[1:0], b_reg[31:2]};
            b_reg <= a_reg;
            a_reg <= t_val;
        end
    end

    assign chain = chain_reg;

endmodule

@@ design/sha1h_checker.sv @@
// ----------------------------------------------------------------------------
// sha1h_checker
// Port-level checks for the SHA-1 byte stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha1h_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_has_byte,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_h0,
    input logic [31:0] out_h4
);

    // A stalled digest word stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("digest word dropped while stalled");

    // A stalled digest word keeps its value.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_h0) && $stable(out_h4))
        else $error("digest word changed while stalled");

    // A last word starts padding, so the input closes.
    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("input still open after last word");

    // An empty, non-last word leaves the input open.
    a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_has_byte && !in_last |=> in_ready)
        else $error("input closed after empty word");

endmodule

bind sha1_byte_stream_hasher_top sha1h_checker u_sha1h_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_has_byte (in_ch.has_byte),
    .in_last     (in_ch.last),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_h0      (out_ch.digest_h0),
    .out_h4      (out_ch.digest_h4)
);
